@@ rtl/lcdc_pkg.sv @@
package lcdc_pkg;

    // Bus access kinds carried on s_tuser
    typedef enum logic [1:0] {
        FN_DATA_RD   = 2'd0,
        FN_STATUS_RD = 2'd1,
        FN_DATA_WR   = 2'd2,
        FN_CMD_WR    = 2'd3
    } func_t;

    // Command groups (upper nibble of the command byte)
    localparam logic [3:0] GRP_POINTER  = 4'h2;
    localparam logic [3:0] GRP_AREA     = 4'h4;
    localparam logic [3:0] GRP_MODE     = 4'h8;
    localparam logic [3:0] GRP_DISPLAY  = 4'h9;
    localparam logic [3:0] GRP_CURSOR   = 4'hA;
    localparam logic [3:0] GRP_AUTO     = 4'hB;
    localparam logic [3:0] GRP_SINGLE   = 4'hC;
    localparam logic [3:0] GRP_BIT      = 4'hF;

    // Sub-codes
    localparam logic [3:0] SUB_CURSOR_POS  = 4'h1;
    localparam logic [3:0] SUB_CGRAM_OFS   = 4'h2;
    localparam logic [3:0] SUB_ADDR_PTR    = 4'h4;
    localparam logic [3:0] SUB_TEXT_HOME   = 4'h0;
    localparam logic [3:0] SUB_TEXT_AREA   = 4'h1;
    localparam logic [3:0] SUB_GFX_HOME    = 4'h2;
    localparam logic [3:0] SUB_GFX_AREA    = 4'h3;
    localparam logic [3:0] SUB_AUTO_WR_ON  = 4'h0;
    localparam logic [3:0] SUB_AUTO_RD_ON  = 4'h1;
    localparam logic [3:0] SUB_AUTO_OFF    = 4'h2;
    localparam logic [3:0] SUB_SINGLE_LAST = 4'h5;
    localparam logic [3:0] SUB_DISPLAY_OFF = 4'h0;

    // Single read/write pointer step, from command bits [2:1]
    localparam logic [1:0] STEP_INC  = 2'd0;
    localparam logic [1:0] STEP_DEC  = 2'd1;

    // Status bit positions
    localparam int unsigned ST_AUTO_RD = 2;
    localparam int unsigned ST_AUTO_WR = 3;
    localparam int unsigned ST_DISP_EN = 5;

    localparam logic [7:0] STATUS_RESET       = 8'hA3;
    localparam logic [3:0] CURSOR_LINES_RESET = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

@@ rtl/lcd_controller_command_port.sv @@
// An accepted transaction moves ST_IDLE to ST_EXEC and loads its result when ST_EXEC
// completes. Acceptance issues the display RAM read at the address pointer; ST_EXEC
//   modifies and writes the entry back. No new transaction is taken before completion.
// A pending result does not block the next acceptance; completion waits for m_tready.
// Reset: aresetn, synchronous, active low; clears control and command state.
//   Display RAM contents are undefined until written.
module lcd_controller_command_port #(
    parameter int RAM_DEPTH = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] read_data, [23:8] address_pointer
);
    import lcdc_pkg::*;

    localparam int ADDR_W = $clog2(RAM_DEPTH);
    localparam logic [23:0] DEPTH_W = 24'(RAM_DEPTH);
    // Reciprocal of the depth scaled by 2^32; exact quotient for any 16-bit word
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << 32) + 64'(RAM_DEPTH) - 64'd1) / 64'(RAM_DEPTH);
    localparam logic [24:0] RECIP = RECIP_FULL[24:0];
    localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(RAM_DEPTH - 1);
    // Entry hit by the pointer after it wraps from 0 to 0xFFFF
    localparam logic [ADDR_W-1:0] IDX_WRAP = ADDR_W'(65535 % RAM_DEPTH);

    state_t state_reg, state_next;

    // Accepted transaction
    logic [1:0]        func_reg;
    logic [7:0]        data_reg;
    logic [ADDR_W-1:0] idx_reg;

    // Command state
    logic [7:0]  arg_first_reg, arg_first_next;
    logic [7:0]  arg_second_reg, arg_second_next;
    logic        arg_sel_first_reg, arg_sel_first_next;
    logic [15:0] addr_ptr_reg, addr_ptr_next;
    logic [7:0]  status_reg, status_next;
    logic [6:0]  cursor_col_reg, cursor_col_next;
    logic [4:0]  cursor_row_reg, cursor_row_next;
    logic [7:0]  cgram_offset_reg, cgram_offset_next;
    logic [15:0] text_home_reg, text_home_next;
    logic [15:0] gfx_home_reg, gfx_home_next;
    logic [7:0]  text_cols_reg, text_cols_next;
    logic [7:0]  gfx_cols_reg, gfx_cols_next;
    logic [2:0]  combine_mode_reg, combine_mode_next;
    logic        ext_chargen_reg, ext_chargen_next;
    logic [3:0]  disp_flags_reg, disp_flags_next;
    logic [3:0]  cursor_lines_reg, cursor_lines_next;

    // RAM index of the address pointer, kept in step with it
    logic [ADDR_W-1:0] ptr_idx_reg, ptr_idx_next;
    logic [ADDR_W-1:0] idx_inc;
    logic [ADDR_W-1:0] idx_dec;
    // RAM index of the argument word, registered from the argument bytes
    logic [ADDR_W-1:0] arg_idx_reg, arg_idx_next;
    logic [7:0]        arg_quot;

    // Output register
    logic        m_valid_reg;
    logic [7:0]  m_rd_reg;
    logic [15:0] m_ptr_reg;

    // RAM port
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [ADDR_W-1:0] ram_idx;

    logic        s_accept;
    logic        exec_done;
    logic [7:0]  rd_value;
    logic [15:0] arg_word;
    logic [3:0]  cmd_grp;
    logic [3:0]  cmd_sub;
    logic [7:0]  bit_mask;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign exec_done = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_ptr_reg, m_rd_reg};

    assign arg_word = {arg_second_reg, arg_first_reg};
    assign cmd_grp  = data_reg[7:4];
    assign cmd_sub  = data_reg[3:0];
    assign bit_mask = 8'(1) << data_reg[2:0];

    // Step the index with the pointer; a 16-bit wrap restarts the modulo sequence
    assign idx_inc = (addr_ptr_reg == 16'hFFFF || ptr_idx_reg == IDX_LAST) ?
                     '0 : ptr_idx_reg + ADDR_W'(1);
    assign idx_dec = (addr_ptr_reg == 16'h0000) ? IDX_WRAP :
                     (ptr_idx_reg == '0) ? IDX_LAST : ptr_idx_reg - ADDR_W'(1);

    // Argument word modulo depth by reciprocal multiplication. The arguments
    // change only at a completion edge, and the next completion needs a fresh
    // acceptance in ST_IDLE first, so the registered index is always current.
    assign arg_quot     = 8'((40'(arg_word) * 40'(RECIP)) >> 32);
    assign arg_idx_next = ADDR_W'(arg_word - 16'(24'(arg_quot) * DEPTH_W));

    assign ram_idx = ptr_idx_reg;

    lcdc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wdata),
        .rd_en   (s_accept),
        .rd_addr (ram_idx),
        .rd_data (ram_rdata)
    );

    // Execute the access against the RAM byte fetched at acceptance
    always_comb begin
        arg_first_next     = arg_first_reg;
        arg_second_next    = arg_second_reg;
        arg_sel_first_next = arg_sel_first_reg;
        addr_ptr_next      = addr_ptr_reg;
        ptr_idx_next       = ptr_idx_reg;
        status_next        = status_reg;
        cursor_col_next    = cursor_col_reg;
        cursor_row_next    = cursor_row_reg;
        cgram_offset_next  = cgram_offset_reg;
        text_home_next     = text_home_reg;
        gfx_home_next      = gfx_home_reg;
        text_cols_next     = text_cols_reg;
        gfx_cols_next      = gfx_cols_reg;
        combine_mode_next  = combine_mode_reg;
        ext_chargen_next   = ext_chargen_reg;
        disp_flags_next    = disp_flags_reg;
        cursor_lines_next  = cursor_lines_reg;
        rd_value           = 8'd0;
        ram_we             = 1'b0;
        ram_wdata          = data_reg;

        case (func_t'(func_reg))
            FN_DATA_RD: begin
                if (status_reg[ST_AUTO_RD]) begin
                    rd_value      = ram_rdata;
                    addr_ptr_next = addr_ptr_reg + 16'd1;
                    ptr_idx_next  = idx_inc;
                end else begin
                    rd_value = arg_first_reg;
                end
            end
            FN_STATUS_RD: begin
                rd_value = status_reg;
            end
            FN_DATA_WR: begin
                if (status_reg[ST_AUTO_WR]) begin
                    ram_we        = 1'b1;
                    ram_wdata     = data_reg;
                    addr_ptr_next = addr_ptr_reg + 16'd1;
                    ptr_idx_next  = idx_inc;
                end else begin
                    if (arg_sel_first_reg) begin
                        arg_first_next = data_reg;
                    end else begin
                        arg_second_next = data_reg;
                    end
                    arg_sel_first_next = !arg_sel_first_reg;
                end
            end
            default: begin
                arg_sel_first_next = 1'b1;
                unique case (cmd_grp)
                    GRP_POINTER: begin
                        if (cmd_sub == SUB_CURSOR_POS) begin
                            cursor_col_next = arg_first_reg[6:0];
                            cursor_row_next = arg_second_reg[4:0];
                        end else if (cmd_sub == SUB_CGRAM_OFS) begin
                            cgram_offset_next = arg_first_reg;
                        end else if (cmd_sub == SUB_ADDR_PTR) begin
                            addr_ptr_next = arg_word;
                            ptr_idx_next  = arg_idx_reg;
                        end
                    end
                    GRP_AREA: begin
                        if (cmd_sub == SUB_TEXT_HOME) begin
                            text_home_next = arg_word;
                        end else if (cmd_sub == SUB_TEXT_AREA) begin
                            text_cols_next = arg_first_reg;
                        end else if (cmd_sub == SUB_GFX_HOME) begin
                            gfx_home_next = arg_word;
                        end else if (cmd_sub == SUB_GFX_AREA) begin
                            gfx_cols_next = arg_first_reg;
                        end
                    end
                    GRP_MODE: begin
                        ext_chargen_next  = data_reg[3];
                        combine_mode_next = data_reg[2:0];
                    end
                    GRP_DISPLAY: begin
                        status_next[ST_DISP_EN] = (cmd_sub != SUB_DISPLAY_OFF);
                        disp_flags_next         = cmd_sub;
                    end
                    GRP_CURSOR: begin
                        cursor_lines_next = {1'b0, data_reg[2:0]} + 4'd1;
                    end
                    GRP_AUTO: begin
                        if (cmd_sub == SUB_AUTO_WR_ON) begin
                            status_next[ST_AUTO_WR] = 1'b1;
                        end else if (cmd_sub == SUB_AUTO_RD_ON) begin
                            status_next[ST_AUTO_RD] = 1'b1;
                        end else if (cmd_sub == SUB_AUTO_OFF) begin
                            status_next[ST_AUTO_RD] = 1'b0;
                            status_next[ST_AUTO_WR] = 1'b0;
                        end
                    end
                    GRP_SINGLE: begin
                        if (cmd_sub <= SUB_SINGLE_LAST) begin
                            if (data_reg[0]) begin
                                arg_first_next = ram_rdata;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = arg_first_reg;
                            end
                            if (data_reg[2:1] == STEP_INC) begin
                                addr_ptr_next = addr_ptr_reg + 16'd1;
                                ptr_idx_next  = idx_inc;
                            end else if (data_reg[2:1] == STEP_DEC) begin
                                addr_ptr_next = addr_ptr_reg - 16'd1;
                                ptr_idx_next  = idx_dec;
                            end
                        end
                    end
                    GRP_BIT: begin
                        ram_we = 1'b1;
                        if (data_reg[3]) begin
                            ram_wdata = ram_rdata | bit_mask;
                        end else begin
                            ram_wdata = ram_rdata & ~bit_mask;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        // Hold the RAM when the result cannot be delivered yet
        if (!exec_done) begin
            ram_we = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Transaction and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tuser;
            data_reg <= s_tdata;
            idx_reg  <= ram_idx;
        end
        if (exec_done) begin
            m_rd_reg  <= rd_value;
            m_ptr_reg <= addr_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            arg_first_reg     <= 8'd0;
            arg_second_reg    <= 8'd0;
            arg_sel_first_reg <= 1'b1;
            addr_ptr_reg      <= 16'd0;
            ptr_idx_reg       <= '0;
            arg_idx_reg       <= '0;
            status_reg        <= STATUS_RESET;
            cursor_col_reg    <= 7'd0;
            cursor_row_reg    <= 5'd0;
            cgram_offset_reg  <= 8'd0;
            text_home_reg     <= 16'd0;
            gfx_home_reg      <= 16'd0;
            text_cols_reg     <= 8'd0;
            gfx_cols_reg      <= 8'd0;
            combine_mode_reg  <= 3'd0;
            ext_chargen_reg   <= 1'b0;
            disp_flags_reg    <= 4'd0;
            cursor_lines_reg  <= CURSOR_LINES_RESET;
        end else begin
            state_reg   <= state_next;
            arg_idx_reg <= arg_idx_next;
            // Drop the result once taken, load a fresh one on completion
            if (exec_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_done) begin
                arg_first_reg     <= arg_first_next;
                arg_second_reg    <= arg_second_next;
                arg_sel_first_reg <= arg_sel_first_next;
                addr_ptr_reg      <= addr_ptr_next;
                ptr_idx_reg       <= ptr_idx_next;
                status_reg        <= status_next;
                cursor_col_reg    <= cursor_col_next;
                cursor_row_reg    <= cursor_row_next;
                cgram_offset_reg  <= cgram_offset_next;
                text_home_reg     <= text_home_next;
                gfx_home_reg      <= gfx_home_next;
                text_cols_reg     <= text_cols_next;
                gfx_cols_reg      <= gfx_cols_next;
                combine_mode_reg  <= combine_mode_next;
                ext_chargen_reg   <= ext_chargen_next;
                disp_flags_reg    <= disp_flags_next;
                cursor_lines_reg  <= cursor_lines_next;
            end
        end
    end

endmodule

@@ rtl/lcdc_ram.sv @@
module lcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ bench/tb_lcd_controller_command_port.sv @@
module tb_lcd_controller_command_port;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdc_pkg::*;

    localparam int RAM_DEPTH    = 8192;
    localparam int RANDOM_ITEMS = 1850;
    localparam int STALL_LIMIT  = 2000;
    localparam int RX_HOLD_LEN  = 300;

    // Command bytes used by the stimulus, built from the package codes
    localparam logic [7:0] CMD_SET_PTR    = {GRP_POINTER, SUB_ADDR_PTR};
    localparam logic [7:0] CMD_AUTO_WR_ON = {GRP_AUTO, SUB_AUTO_WR_ON};
    localparam logic [7:0] CMD_AUTO_RD_ON = {GRP_AUTO, SUB_AUTO_RD_ON};
    localparam logic [7:0] CMD_AUTO_OFF   = {GRP_AUTO, SUB_AUTO_OFF};
    localparam logic [7:0] CMD_RD_INC     = {GRP_SINGLE, 1'b0, STEP_INC, 1'b1};
    localparam logic [7:0] CMD_WR_DEC     = {GRP_SINGLE, 1'b0, STEP_DEC, 1'b0};
    localparam logic [7:0] CMD_RD_DEC     = {GRP_SINGLE, 1'b0, STEP_DEC, 1'b1};
    localparam logic [7:0] CMD_WR_KEEP    = {GRP_SINGLE, SUB_SINGLE_LAST - 4'd1};
    localparam logic [7:0] CMD_RD_KEEP    = {GRP_SINGLE, SUB_SINGLE_LAST};
    localparam logic [7:0] CMD_SINGLE_BAD = {GRP_SINGLE, SUB_SINGLE_LAST + 4'd1};
    localparam logic [7:0] CMD_BIT_CLR0   = {GRP_BIT, 4'h0};
    localparam logic [7:0] CMD_BIT_SET7   = {GRP_BIT, 4'hF};
    localparam logic [7:0] CMD_DISP_OFF   = {GRP_DISPLAY, SUB_DISPLAY_OFF};
    localparam logic [7:0] CMD_DISP_ALL   = {GRP_DISPLAY, 4'hF};
    localparam logic [7:0] CMD_MODE_MAX   = {GRP_MODE, 4'hF};
    localparam logic [7:0] CMD_CURSOR_MAX = {GRP_CURSOR, 4'h7};
    localparam logic [7:0] CMD_PEEK       = 8'hE0;
    localparam logic [7:0] CMD_REFRESH    = 8'h10;

    // Packed in the same order as m_tdata
    typedef struct packed {
        logic [15:0] address_pointer;
        logic [7:0]  read_data;
    } port_reply_t;

    typedef struct packed {
        func_t       fn;
        logic [7:0]  dbyte;
        bit          pinned;
        port_reply_t want;
    } bus_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = FN_DATA_RD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    lcd_controller_command_port #(
        .RAM_DEPTH(RAM_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shadow of the controller state, advanced once per accepted transaction
    logic [7:0]  ram_img   [RAM_DEPTH];
    bit          ram_valid [RAM_DEPTH];
    logic [7:0]  arg_lo      = 8'h00;
    logic [7:0]  arg_hi      = 8'h00;
    bit          arg_sel_lo  = 1'b1;
    logic [15:0] ptr         = 16'h0000;
    logic [7:0]  status      = STATUS_RESET;
    logic [6:0]  cur_col     = '0;
    logic [4:0]  cur_row     = '0;
    logic [7:0]  cg_ofs      = '0;
    logic [15:0] txt_home    = '0;
    logic [15:0] gfx_home    = '0;
    logic [7:0]  txt_cols    = '0;
    logic [7:0]  gfx_cols    = '0;
    logic [2:0]  comb_mode   = '0;
    logic        ext_cg      = 1'b0;
    logic [3:0]  disp_flags  = '0;
    logic [3:0]  cur_lines   = CURSOR_LINES_RESET;

    port_reply_t reply_q [$];
    bit          pin_active = 1'b0;
    port_reply_t pin_reply  = '0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    int          src_idle_pct = 0;
    int          rx_idle_pct  = 0;
    int          rx_hold_cycles = 0;

    // Directed part: pinned rows carry a fixed reply that follows from the rows before them
    bus_row_t directed_rows [28] = '{
        '{FN_STATUS_RD, 8'h00,          1'b1, '{16'h0000, 8'hA3}},
        '{FN_DATA_RD,   8'hFF,          1'b1, '{16'h0000, 8'h00}},
        '{FN_DATA_WR,   8'hFF,          1'b1, '{16'h0000, 8'h00}},
        '{FN_DATA_WR,   8'hFF,          1'b1, '{16'h0000, 8'h00}},
        '{FN_CMD_WR,    CMD_SET_PTR,    1'b1, '{16'hFFFF, 8'h00}},
        '{FN_CMD_WR,    CMD_AUTO_WR_ON, 1'b0, '0},
        '{FN_DATA_WR,   8'h00,          1'b1, '{16'h0000, 8'h00}},
        '{FN_DATA_WR,   8'hA5,          1'b0, '0},
        '{FN_CMD_WR,    CMD_AUTO_OFF,   1'b0, '0},
        '{FN_CMD_WR,    CMD_WR_DEC,     1'b0, '0},
        '{FN_CMD_WR,    CMD_RD_INC,     1'b0, '0},
        '{FN_DATA_RD,   8'h00,          1'b0, '0},
        '{FN_CMD_WR,    CMD_RD_DEC,     1'b0, '0},
        '{FN_CMD_WR,    CMD_RD_KEEP,    1'b0, '0},
        '{FN_CMD_WR,    CMD_WR_KEEP,    1'b0, '0},
        '{FN_CMD_WR,    CMD_BIT_CLR0,   1'b0, '0},
        '{FN_CMD_WR,    CMD_BIT_SET7,   1'b0, '0},
        '{FN_CMD_WR,    CMD_AUTO_RD_ON, 1'b0, '0},
        '{FN_DATA_RD,   8'h00,          1'b0, '0},
        '{FN_DATA_RD,   8'hFF,          1'b0, '0},
        '{FN_CMD_WR,    CMD_DISP_OFF,   1'b0, '0},
        '{FN_STATUS_RD, 8'hFF,          1'b1, '{16'h0002, 8'h87}},
        '{FN_CMD_WR,    CMD_DISP_ALL,   1'b0, '0},
        '{FN_CMD_WR,    CMD_CURSOR_MAX, 1'b0, '0},
        '{FN_CMD_WR,    CMD_PEEK,       1'b0, '0},
        '{FN_CMD_WR,    CMD_REFRESH,    1'b0, '0},
        '{FN_CMD_WR,    CMD_MODE_MAX,   1'b0, '0},
        '{FN_CMD_WR,    CMD_SINGLE_BAD, 1'b0, '0}
    };

    // Advance the shadow state by one bus access and return the reply it produces
    function automatic port_reply_t apply_bus_access(input func_t fn, input logic [7:0] dbyte);
        port_reply_t r;
        int unsigned ix;
        logic [3:0]  sub;
        ix  = ptr % RAM_DEPTH;
        sub = dbyte[3:0];
        r.read_data = 8'h00;
        case (fn)
            FN_DATA_RD: begin
                if (status[ST_AUTO_RD]) begin
                    r.read_data = ram_img[ix];
                    ptr = ptr + 16'd1;
                end else begin
                    r.read_data = arg_lo;
                end
            end
            FN_STATUS_RD: begin
                r.read_data = status;
            end
            FN_DATA_WR: begin
                if (status[ST_AUTO_WR]) begin
                    ram_img[ix]   = dbyte;
                    ram_valid[ix] = 1'b1;
                    ptr = ptr + 16'd1;
                end else begin
                    if (arg_sel_lo)
                        arg_lo = dbyte;
                    else
                        arg_hi = dbyte;
                    arg_sel_lo = !arg_sel_lo;
                end
            end
            FN_CMD_WR: begin
                case (dbyte[7:4])
                    GRP_POINTER: begin
                        if (sub == SUB_CURSOR_POS) begin
                            cur_col = arg_lo[6:0];
                            cur_row = arg_hi[4:0];
                        end else if (sub == SUB_CGRAM_OFS) begin
                            cg_ofs = arg_lo;
                        end else if (sub == SUB_ADDR_PTR) begin
                            ptr = {arg_hi, arg_lo};
                        end
                    end
                    GRP_AREA: begin
                        if (sub == SUB_TEXT_HOME)
                            txt_home = {arg_hi, arg_lo};
                        else if (sub == SUB_TEXT_AREA)
                            txt_cols = arg_lo;
                        else if (sub == SUB_GFX_HOME)
                            gfx_home = {arg_hi, arg_lo};
                        else if (sub == SUB_GFX_AREA)
                            gfx_cols = arg_lo;
                    end
                    GRP_MODE: begin
                        ext_cg    = dbyte[3];
                        comb_mode = dbyte[2:0];
                    end
                    GRP_DISPLAY: begin
                        status[ST_DISP_EN] = (sub != SUB_DISPLAY_OFF);
                        disp_flags = sub;
                    end
                    GRP_CURSOR: begin
                        cur_lines = {1'b0, dbyte[2:0]} + 4'd1;
                    end
                    GRP_AUTO: begin
                        if (sub == SUB_AUTO_WR_ON) begin
                            status[ST_AUTO_WR] = 1'b1;
                        end else if (sub == SUB_AUTO_RD_ON) begin
                            status[ST_AUTO_RD] = 1'b1;
                        end else if (sub == SUB_AUTO_OFF) begin
                            status[ST_AUTO_RD] = 1'b0;
                            status[ST_AUTO_WR] = 1'b0;
                        end
                    end
                    GRP_SINGLE: begin
                        if (sub <= SUB_SINGLE_LAST) begin
                            if (dbyte[0]) begin
                                arg_lo = ram_img[ix];
                            end else begin
                                ram_img[ix]   = arg_lo;
                                ram_valid[ix] = 1'b1;
                            end
                            if (dbyte[2:1] == STEP_INC)
                                ptr = ptr + 16'd1;
                            else if (dbyte[2:1] == STEP_DEC)
                                ptr = ptr - 16'd1;
                        end
                    end
                    GRP_BIT: begin
                        ram_img[ix][dbyte[2:0]] = dbyte[3];
                    end
                    default: ;
                endcase
                arg_sel_lo = 1'b1;
            end
            default: ;
        endcase
        r.address_pointer = ptr;
        return r;
    endfunction

    // True when the access would read a display RAM entry never written so far
    function automatic bit hits_unwritten_ram(input func_t fn, input logic [7:0] dbyte);
        int unsigned ix;
        ix = ptr % RAM_DEPTH;
        if (ram_valid[ix])
            return 1'b0;
        if (fn == FN_DATA_RD)
            return status[ST_AUTO_RD];
        if (fn == FN_CMD_WR) begin
            if (dbyte[7:4] == GRP_SINGLE && dbyte[3:0] <= SUB_SINGLE_LAST && dbyte[0])
                return 1'b1;
            if (dbyte[7:4] == GRP_BIT)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Check replies first, then queue the reply of a transaction accepted at this edge
    always @(posedge aclk) begin
        port_reply_t got;
        port_reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (reply_q.size() == 0) begin
                    $error("unexpected reply %h with nothing outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               want.read_data, got.read_data);
                        fail_count++;
                    end
                    if (got.address_pointer !== want.address_pointer) begin
                        $error("address_pointer: expected %h, actual %h",
                               want.address_pointer, got.address_pointer);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_bus_access(func_t'(s_tuser), s_tdata);
                if (pin_active)
                    want = pin_reply;
                reply_q.insert(reply_q.size(), want);
            end
        end
    end

    // Abort when neither side has moved a transaction for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random backpressure, or a long hold when one is requested
    always @(negedge aclk) begin
        if (rx_hold_cycles != 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one transaction and hold it until accepted; returns at a falling edge
    task automatic send(input func_t fn, input logic [7:0] dbyte,
                        input bit pin = 1'b0, input port_reply_t pin_val = '0);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        if (hits_unwritten_ram(fn, dbyte)) begin
            fn  = FN_STATUS_RD;
            pin = 1'b0;
        end
        pin_active = pin;
        pin_reply  = pin_val;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= dbyte;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop valid and wait until every queued reply has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Load both argument bytes in order, then issue the command that uses them
    task automatic send_with_args(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [7:0] cmd);
        if (status[ST_AUTO_WR])
            send(FN_CMD_WR, CMD_AUTO_OFF);
        else if (!arg_sel_lo)
            send(FN_CMD_WR, CMD_PEEK);
        send(FN_DATA_WR, lo);
        send(FN_DATA_WR, hi);
        send(FN_CMD_WR, cmd);
    endtask

    // Favor the bottom, the RAM wrap, the 16-bit wrap and an aliased region
    function automatic logic [15:0] pick_ptr();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 63));
            1:       return 16'($urandom_range(16'h1FF0, 16'h200F));
            2:       return 16'($urandom_range(16'hFFF0, 16'hFFFF));
            3:       return 16'($urandom_range(16'h3FF0, 16'h400F));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_scenario();
        int unsigned pick;
        int unsigned n;
        logic [15:0] base;
        logic [15:0] spot;
        logic [3:0]  grp;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // RAM round trip: fill a block, read it back, then poke single entries
            base = pick_ptr();
            n = $urandom_range(1, 8);
            send_with_args(base[7:0], base[15:8], CMD_SET_PTR);
            send(FN_CMD_WR, CMD_AUTO_WR_ON);
            repeat (n) send(FN_DATA_WR, 8'($urandom));
            send(FN_CMD_WR, CMD_AUTO_OFF);
            send_with_args(base[7:0], base[15:8], CMD_SET_PTR);
            send(FN_CMD_WR, CMD_AUTO_RD_ON);
            repeat (n) send(FN_DATA_RD, 8'($urandom));
            send(FN_CMD_WR, CMD_AUTO_OFF);
            repeat ($urandom_range(1, 4)) begin
                spot = base + 16'($urandom_range(0, n - 1));
                send_with_args(spot[7:0], spot[15:8], CMD_SET_PTR);
                if ($urandom_range(0, 1))
                    send(FN_DATA_WR, 8'($urandom));
                if ($urandom_range(0, 1))
                    send(FN_CMD_WR, {GRP_SINGLE, 4'($urandom_range(0, 7))});
                else
                    send(FN_CMD_WR, {GRP_BIT, 4'($urandom)});
                send(FN_DATA_RD, 8'($urandom));
            end
        end else if (pick < 55) begin
            // Argument commands, mostly known sub-codes
            case ($urandom_range(0, 7))
                0:       grp = SUB_CURSOR_POS;
                1:       grp = SUB_CGRAM_OFS;
                2:       grp = SUB_ADDR_PTR;
                default: grp = 4'($urandom);
            endcase
            if ($urandom_range(0, 1))
                send_with_args(8'($urandom), 8'($urandom), {GRP_POINTER, grp});
            else
                send_with_args(8'($urandom), 8'($urandom),
                               {GRP_AREA, 4'($urandom_range(0, 5))});
        end else if (pick < 70) begin
            case ($urandom_range(0, 3))
                0:       grp = GRP_MODE;
                1:       grp = GRP_DISPLAY;
                2:       grp = GRP_CURSOR;
                default: grp = GRP_AUTO;
            endcase
            send(FN_CMD_WR, {grp, 4'($urandom)});
            send(FN_STATUS_RD, 8'($urandom));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3))
                send(func_t'($urandom_range(0, 2)), 8'($urandom));
        end else begin
            // Noise: any access kind, any byte
            repeat ($urandom_range(1, 4))
                send(func_t'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    initial begin
        int phase_goal;
        src_idle_pct = 6;
        rx_idle_pct  = 76;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send(directed_rows[i].fn, directed_rows[i].dbyte,
                 directed_rows[i].pinned, directed_rows[i].want);
        wait_idle();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 6;
                    rx_idle_pct  = 76;
                end
                1: begin
                    src_idle_pct = 76;
                    rx_idle_pct  = 6;
                end
                default: begin
                    src_idle_pct = 0;
                    rx_idle_pct  = 0;
                    // Hold the result side off while the input keeps offering
                    rx_hold_cycles = RX_HOLD_LEN;
                    repeat (16) send(func_t'($urandom_range(0, 3)), 8'($urandom));
                    wait_idle();
                end
            endcase
            phase_goal = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < phase_goal)
                run_scenario();
            wait_idle();
        end

        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
